/* rtl/mcc_pkg.sv */
// Shared widths, codes and defaults for the MOSI coherence controller.
`timescale 1ns / 1ps

package mcc_pkg;

   localparam int unsigned LINES_DEFAULT = 1024;

   localparam int unsigned OP_W   = 3;
   localparam int unsigned ADDR_W = 32;
   localparam int unsigned NODE_W = 4;
   localparam int unsigned BUS_W  = 2;
   localparam int unsigned ST_W   = 3;
   localparam int unsigned CNT_W  = 32;

   localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
   localparam logic [OP_W-1:0] OP_STORE = 3'd1;
   localparam logic [OP_W-1:0] OP_GETS  = 3'd2;
   localparam logic [OP_W-1:0] OP_GETM  = 3'd3;
   localparam logic [OP_W-1:0] OP_DATA  = 3'd4;

   localparam logic [BUS_W-1:0] BUS_NONE = 2'd0;
   localparam logic [BUS_W-1:0] BUS_GETS = 2'd1;
   localparam logic [BUS_W-1:0] BUS_GETM = 2'd2;

   localparam logic [ST_W-1:0] ST_I  = 3'd0;
   localparam logic [ST_W-1:0] ST_S  = 3'd1;
   localparam logic [ST_W-1:0] ST_O  = 3'd2;
   localparam logic [ST_W-1:0] ST_M  = 3'd3;
   localparam logic [ST_W-1:0] ST_IS = 3'd4;
   localparam logic [ST_W-1:0] ST_IM = 3'd5;
   localparam logic [ST_W-1:0] ST_OM = 3'd6;

   typedef struct packed {
      logic [BUS_W-1:0]  bus_request;
      logic              supply_data;
      logic [NODE_W-1:0] supply_dest;
      logic              reply_to_proc;
      logic              miss;
      logic              illegal;
      logic [ST_W-1:0]   new_state;
   } mcc_act_type;

endpackage

/* rtl/mcc_req_if.sv */
// Request channel: processor accesses and snooped bus messages.
`timescale 1ns / 1ps

interface mcc_req_if import mcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [ADDR_W-1:0] line_addr;
   logic [NODE_W-1:0] requester;

   modport source (output valid, output op, output line_addr, output requester,
                   input ready);
   modport sink   (input valid, input op, input line_addr, input requester,
                   output ready);
endinterface

/* rtl/mcc_rsp_if.sv */
// Response channel: coherence actions and resulting line state.
`timescale 1ns / 1ps

interface mcc_rsp_if import mcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BUS_W-1:0]  bus_request;
   logic              supply_data;
   logic [NODE_W-1:0] supply_dest;
   logic              reply_to_proc;
   logic [ADDR_W-1:0] out_addr;
   logic              miss;
   logic [CNT_W-1:0]  miss_total;
   logic              illegal;
   logic [ST_W-1:0]   new_state;

   modport source (output valid, output bus_request, output supply_data,
                   output supply_dest, output reply_to_proc, output out_addr,
                   output miss, output miss_total, output illegal, output new_state,
                   input ready);
   modport sink   (input valid, input bus_request, input supply_data,
                   input supply_dest, input reply_to_proc, input out_addr,
                   input miss, input miss_total, input illegal, input new_state,
                   output ready);
endinterface

/* rtl/mcc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mcc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/mosi_coherence_controller_core.sv */
// Top level of the snooping MOSI coherence controller with line state RAM.
`timescale 1ns / 1ps
//
//  channel   dir  handshake        transaction contents
//  req_ch    in   valid / ready    op, line_addr, requester
//  rsp_ch    out  valid / ready    bus_request, supply_data, supply_dest, reply_to_proc,
//                                  out_addr, miss, miss_total, illegal, new_state
//
//  One transaction per cycle sustained while rsp_ch is ready.
//  Stages: index reduction (line_addr mod LINES, three stages), then state RAM read,
//  whose registered data is updated and written back in the last stage.
//  A write-back register forwards the latest line state to a following access.
//  After reset, the state RAM is cleared to I line by line; req_ch.ready is low meanwhile.
//  A stalled rsp_ch freezes the whole pipeline.

module mosi_coherence_controller_core import mcc_pkg::*; #(
   parameter int unsigned LINES = LINES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   mcc_req_if.sink    req_ch,
   mcc_rsp_if.source  rsp_ch
);

   localparam int unsigned IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int unsigned X_W   = 26;
   localparam int unsigned M_W   = X_W + 1;
   localparam int unsigned RED_W = 17;
   localparam int unsigned W_W   = 16;
   localparam logic [M_W-1:0]   RECIP  = M_W'((64'd1 << X_W) / LINES);
   localparam logic [W_W-1:0]   WGT0   = W_W'(64'd1 % LINES);
   localparam logic [W_W-1:0]   WGT1   = W_W'((64'd1 << 8) % LINES);
   localparam logic [W_W-1:0]   WGT2   = W_W'((64'd1 << 16) % LINES);
   localparam logic [W_W-1:0]   WGT3   = W_W'((64'd1 << 24) % LINES);
   localparam logic [RED_W-1:0] LINES_C = RED_W'(LINES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   logic advance;
   logic accept;

   logic clear_active_ff;
   logic [IDX_W-1:0] clear_idx_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [OP_W-1:0]   op1_ff, op2_ff, op3_ff, op4_ff;
   logic [ADDR_W-1:0] addr1_ff, addr2_ff, addr3_ff, addr4_ff;
   logic [NODE_W-1:0] req1_ff, req2_ff, req3_ff, req4_ff;
   logic [X_W-1:0]    x_in, x1_ff, x2_ff;
   logic [X_W+M_W-1:0] prod_in;
   logic [X_W-1:0]    q2_ff;
   logic [X_W+RED_W-1:0] ql_in;
   logic [X_W-1:0]    r_full_in;
   logic [RED_W-1:0]  r3_ff;
   logic [RED_W-1:0]  r_fix_in;
   logic [IDX_W-1:0]  idx_rd_in, idx4_ff;

   logic [ST_W-1:0]  ram_rdata;
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [ST_W-1:0]  ram_wdata;

   logic             fwd_valid_ff;
   logic [IDX_W-1:0] fwd_idx_ff;
   logic [ST_W-1:0]  fwd_state_ff;
   logic [ST_W-1:0]  cur_state;
   mcc_act_type      act;
   logic             is_store;
   logic             commit;

   logic [CNT_W-1:0] miss_count_ff, miss_count_in;

   logic              rsp_valid_ff;
   mcc_act_type       rsp_act_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [CNT_W-1:0]  rsp_total_ff;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance && !clear_active_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign commit       = v4_ff && advance;

   // line_addr mod LINES: byte-weighted fold, reciprocal quotient, one correction
   assign x_in = (X_W'(req_ch.line_addr[7:0]) * X_W'(WGT0))
               + (X_W'(req_ch.line_addr[15:8]) * X_W'(WGT1))
               + (X_W'(req_ch.line_addr[23:16]) * X_W'(WGT2))
               + (X_W'(req_ch.line_addr[31:24]) * X_W'(WGT3));
   assign prod_in   = x1_ff * RECIP;
   assign ql_in     = q2_ff * LINES_C;
   assign r_full_in = x2_ff - ql_in[X_W-1:0];
   assign r_fix_in  = (r3_ff >= LINES_C) ? (r3_ff - LINES_C) : r3_ff;
   assign idx_rd_in = r_fix_in[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_idx_ff    <= '0;
      end else if (clear_active_ff) begin
         if (clear_idx_ff == LAST_IDX) begin
            clear_active_ff <= 1'b0;
         end
         clear_idx_ff <= clear_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op1_ff   <= req_ch.op;
         addr1_ff <= req_ch.line_addr;
         req1_ff  <= req_ch.requester;
         x1_ff    <= x_in;
         op2_ff   <= op1_ff;
         addr2_ff <= addr1_ff;
         req2_ff  <= req1_ff;
         x2_ff    <= x1_ff;
         q2_ff    <= prod_in[X_W+X_W-1:X_W];
         op3_ff   <= op2_ff;
         addr3_ff <= addr2_ff;
         req3_ff  <= req2_ff;
         r3_ff    <= r_full_in[RED_W-1:0];
         op4_ff   <= op3_ff;
         addr4_ff <= addr3_ff;
         req4_ff  <= req3_ff;
         idx4_ff  <= idx_rd_in;
      end
   end

   assign ram_we    = clear_active_ff || commit;
   assign ram_waddr = clear_active_ff ? clear_idx_ff : idx4_ff;
   assign ram_wdata = clear_active_ff ? ST_I : act.new_state;

   mcc_ram #(
      .WIDTH (ST_W),
      .DEPTH (LINES)
   ) u_state_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (advance),
      .raddr (idx_rd_in),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (commit) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         fwd_idx_ff   <= idx4_ff;
         fwd_state_ff <= act.new_state;
      end
   end

   assign cur_state = (fwd_valid_ff && (fwd_idx_ff == idx4_ff)) ? fwd_state_ff : ram_rdata;
   assign is_store  = (op4_ff == OP_STORE);

   always_comb begin
      act             = '0;
      act.bus_request = BUS_NONE;
      act.new_state   = cur_state;
      unique case (op4_ff)
         OP_LOAD, OP_STORE: begin
            unique case (cur_state)
               ST_I: begin
                  act.bus_request = is_store ? BUS_GETM : BUS_GETS;
                  act.new_state   = is_store ? ST_IM : ST_IS;
                  act.miss        = 1'b1;
               end
               ST_S: begin
                  if (is_store) begin
                     act.bus_request = BUS_GETM;
                     act.new_state   = ST_IM;
                     act.miss        = 1'b1;
                  end else begin
                     act.reply_to_proc = 1'b1;
                  end
               end
               ST_O: begin
                  if (is_store) begin
                     act.bus_request = BUS_GETM;
                     act.new_state   = ST_OM;
                     act.miss        = 1'b1;
                  end else begin
                     act.reply_to_proc = 1'b1;
                  end
               end
               ST_M: begin
                  act.reply_to_proc = 1'b1;
               end
               default: begin
                  act.illegal = 1'b1;
               end
            endcase
         end
         OP_GETS, OP_GETM, OP_DATA: begin
            unique case (cur_state)
               ST_I: begin
               end
               ST_S: begin
                  if (op4_ff == OP_GETM) begin
                     act.new_state = ST_I;
                  end else if (op4_ff == OP_DATA) begin
                     act.illegal = 1'b1;
                  end
               end
               ST_O: begin
                  if (op4_ff == OP_DATA) begin
                     act.illegal = 1'b1;
                  end else begin
                     act.supply_data = 1'b1;
                     if (op4_ff == OP_GETM) begin
                        act.new_state = ST_I;
                     end
                  end
               end
               ST_M: begin
                  if (op4_ff == OP_DATA) begin
                     act.illegal = 1'b1;
                  end else begin
                     act.supply_data = 1'b1;
                     act.new_state   = (op4_ff == OP_GETM) ? ST_I : ST_O;
                  end
               end
               ST_IS: begin
                  if (op4_ff == OP_DATA) begin
                     act.reply_to_proc = 1'b1;
                     act.new_state     = ST_S;
                  end
               end
               ST_IM: begin
                  if (op4_ff == OP_DATA) begin
                     act.reply_to_proc = 1'b1;
                     act.new_state     = ST_M;
                  end
               end
               ST_OM: begin
                  if (op4_ff == OP_DATA) begin
                     act.reply_to_proc = 1'b1;
                     act.new_state     = ST_M;
                  end else begin
                     act.supply_data = 1'b1;
                     if (op4_ff == OP_GETM) begin
                        act.new_state = ST_IM;
                     end
                  end
               end
               default: begin
                  act.illegal = 1'b1;
               end
            endcase
         end
         default: begin
            act.illegal = 1'b1;
         end
      endcase
      act.supply_dest = act.supply_data ? req4_ff : '0;
   end

   assign miss_count_in = (act.miss && (miss_count_ff != CNT_MAX)) ? (miss_count_ff + 1'b1)
                                                                    : miss_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_count_ff <= '0;
      end else if (commit) begin
         miss_count_ff <= miss_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_act_ff   <= act;
         rsp_addr_ff  <= addr4_ff;
         rsp_total_ff <= miss_count_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.bus_request   = rsp_act_ff.bus_request;
   assign rsp_ch.supply_data   = rsp_act_ff.supply_data;
   assign rsp_ch.supply_dest   = rsp_act_ff.supply_dest;
   assign rsp_ch.reply_to_proc = rsp_act_ff.reply_to_proc;
   assign rsp_ch.out_addr      = rsp_addr_ff;
   assign rsp_ch.miss          = rsp_act_ff.miss;
   assign rsp_ch.miss_total    = rsp_total_ff;
   assign rsp_ch.illegal       = rsp_act_ff.illegal;
   assign rsp_ch.new_state     = rsp_act_ff.new_state;

   a_clear_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> !(v1_ff || v2_ff || v3_ff || v4_ff))
      else $error("transaction in flight during state RAM clear");

   a_illegal_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_act_ff.illegal) |->
         (rsp_act_ff.bus_request == BUS_NONE) && !rsp_act_ff.supply_data &&
         !rsp_act_ff.reply_to_proc && !rsp_act_ff.miss)
      else $error("illegal transaction produced an action");

   a_miss_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (miss_count_ff >= $past(miss_count_ff)))
      else $error("miss count decreased");

   a_written_state_legal: assert property (@(posedge clock) disable iff (reset)
      commit |-> (act.new_state <= ST_OM))
      else $error("undefined line state written");

endmodule

/* tb/mosi_coherence_controller_core_test.sv */
// Self-checking testbench for the MOSI coherence controller core.
`timescale 1ns / 1ps

module mosi_coherence_controller_core_test;
   import mcc_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 2000;
   localparam int unsigned HOLD_AFTER   = 700;
   localparam int unsigned TAIL_ITEMS   = 200;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned MAX_PRINTS   = 30;
   localparam int unsigned DIRECTED_N   = 29;

   typedef struct packed {
      logic [BUS_W-1:0]  bus_request;
      logic              supply_data;
      logic [NODE_W-1:0] supply_dest;
      logic              reply_to_proc;
      logic [ADDR_W-1:0] out_addr;
      logic              miss;
      logic [CNT_W-1:0]  miss_total;
      logic              illegal;
      logic [ST_W-1:0]   new_state;
   } coherence_outcome_type;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [ADDR_W-1:0]     line_addr;
      logic [NODE_W-1:0]     requester;
      logic                  has_outcome;
      coherence_outcome_type outcome;
   } directed_row_type;

   typedef enum logic [1:0] {EFFECT_ACTS, EFFECT_IGNORED, EFFECT_ILLEGAL} item_effect_type;

   logic clock;
   logic reset;

   mcc_req_if req_ch ();
   mcc_rsp_if rsp_ch ();

   mosi_coherence_controller_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [ST_W-1:0]       line_state_model [LINES_DEFAULT];
   logic [CNT_W-1:0]      miss_count_model;
   coherence_outcome_type pending_outcomes [$];
   coherence_outcome_type oldest;
   directed_row_type      directed_rows [DIRECTED_N];

   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned checked_count;
   int unsigned miss_seen;
   int unsigned illegal_seen;
   int unsigned supply_seen;
   int unsigned reply_seen;
   bit          hold_off_due;
   bit          tail_phase;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic coherence_outcome_type predict_coherence(
      logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr, logic [NODE_W-1:0] requester);
      coherence_outcome_type o;
      int unsigned           idx;
      logic [ST_W-1:0]       cur;
      logic                  bad;
      idx = addr % LINES_DEFAULT;
      cur = line_state_model[idx];
      o = '0;
      o.out_addr = addr;
      o.new_state = cur;
      bad = 1'b0;
      case (op)
         OP_LOAD, OP_STORE: begin
            case (cur)
               ST_I: begin
                  o.bus_request = (op == OP_STORE) ? BUS_GETM : BUS_GETS;
                  o.new_state = (op == OP_STORE) ? ST_IM : ST_IS;
                  o.miss = 1'b1;
               end
               ST_S, ST_O: begin
                  if (op == OP_STORE) begin
                     o.bus_request = BUS_GETM;
                     o.new_state = (cur == ST_S) ? ST_IM : ST_OM;
                     o.miss = 1'b1;
                  end else begin
                     o.reply_to_proc = 1'b1;
                  end
               end
               ST_M: o.reply_to_proc = 1'b1;
               default: bad = 1'b1;
            endcase
         end
         OP_GETS, OP_GETM, OP_DATA: begin
            case (cur)
               ST_I: ;
               ST_S: begin
                  if (op == OP_GETM) o.new_state = ST_I;
                  else if (op == OP_DATA) bad = 1'b1;
               end
               ST_O: begin
                  if (op == OP_DATA) begin
                     bad = 1'b1;
                  end else begin
                     o.supply_data = 1'b1;
                     if (op == OP_GETM) o.new_state = ST_I;
                  end
               end
               ST_M: begin
                  if (op == OP_DATA) begin
                     bad = 1'b1;
                  end else begin
                     o.supply_data = 1'b1;
                     o.new_state = (op == OP_GETM) ? ST_I : ST_O;
                  end
               end
               ST_IS, ST_IM: begin
                  if (op == OP_DATA) begin
                     o.reply_to_proc = 1'b1;
                     o.new_state = (cur == ST_IS) ? ST_S : ST_M;
                  end
               end
               ST_OM: begin
                  if (op == OP_DATA) begin
                     o.reply_to_proc = 1'b1;
                     o.new_state = ST_M;
                  end else begin
                     o.supply_data = 1'b1;
                     if (op == OP_GETM) o.new_state = ST_IM;
                  end
               end
               default: bad = 1'b1;
            endcase
         end
         default: bad = 1'b1;
      endcase
      if (bad) begin
         o.bus_request = BUS_NONE;
         o.supply_data = 1'b0;
         o.reply_to_proc = 1'b0;
         o.miss = 1'b0;
         o.new_state = cur;
      end
      if (o.supply_data) o.supply_dest = requester;
      if (o.miss && miss_count_model != '1) miss_count_model++;
      o.miss_total = miss_count_model;
      o.illegal = bad;
      line_state_model[idx] = o.new_state;
      return o;
   endfunction

   function automatic item_effect_type effect_of(logic [OP_W-1:0] op, logic [ST_W-1:0] st);
      if (op > OP_DATA || (op <= OP_STORE && st >= ST_IS) ||
          (op == OP_DATA && (st == ST_S || st == ST_O || st == ST_M)))
         return EFFECT_ILLEGAL;
      if (op >= OP_GETS && (st == ST_I || (op != OP_DATA && (st == ST_IS || st == ST_IM))))
         return EFFECT_IGNORED;
      return EFFECT_ACTS;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("mismatch %0d at cycle %0d: %s got %0h expected %0h",
                  error_count, cycle_count, what, got, want);
   endtask

   task automatic offer(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                        input logic [NODE_W-1:0] requester, input logic has_outcome,
                        input coherence_outcome_type outcome);
      coherence_outcome_type predicted;
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.line_addr <= addr;
      req_ch.requester <= requester;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = predict_coherence(op, addr, requester);
      pending_outcomes.push_back(has_outcome ? outcome : predicted);
      if (!tail_phase && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int unsigned       item_count;
      int unsigned       idx;
      int unsigned       hot_lines [8];
      bit                hold_issued;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [ST_W-1:0]   st;

      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_LOAD;
      req_ch.line_addr <= '0;
      req_ch.requester <= '0;
      for (int i = 0; i < LINES_DEFAULT; i++) line_state_model[i] = ST_I;
      miss_count_model = '0;
      hold_issued = 1'b0;
      item_count = 0;

      directed_rows = '{
         '{OP_LOAD,  32'h0000_0000, 4'h0, 1'b1,
           '{BUS_GETS, 1'b0, 4'h0, 1'b0, 32'h0000_0000, 1'b1, 32'd1, 1'b0, ST_IS}},
         '{OP_LOAD,  32'h0000_0000, 4'h0, 1'b1,
           '{BUS_NONE, 1'b0, 4'h0, 1'b0, 32'h0000_0000, 1'b0, 32'd1, 1'b1, ST_IS}},
         '{OP_GETS,  32'h0000_0000, 4'hF, 1'b0, '0},
         '{OP_DATA,  32'h0000_0000, 4'h0, 1'b0, '0},
         '{OP_DATA,  32'h0000_0000, 4'h0, 1'b1,
           '{BUS_NONE, 1'b0, 4'h0, 1'b0, 32'h0000_0000, 1'b0, 32'd1, 1'b1, ST_S}},
         '{OP_LOAD,  32'h0000_0000, 4'h0, 1'b0, '0},
         '{OP_STORE, 32'h0000_0000, 4'h0, 1'b0, '0},
         '{OP_STORE, 32'h0000_0000, 4'h0, 1'b1,
           '{BUS_NONE, 1'b0, 4'h0, 1'b0, 32'h0000_0000, 1'b0, 32'd2, 1'b1, ST_IM}},
         '{OP_GETM,  32'h0000_0000, 4'h5, 1'b0, '0},
         '{OP_DATA,  32'h0000_0000, 4'h0, 1'b0, '0},
         '{OP_STORE, 32'h0000_0000, 4'h0, 1'b0, '0},
         '{OP_GETS,  32'h0000_0000, 4'hF, 1'b0, '0},
         '{OP_LOAD,  32'h0000_0000, 4'h0, 1'b0, '0},
         '{OP_STORE, 32'h0000_0000, 4'h0, 1'b0, '0},
         '{OP_GETS,  32'h0000_0000, 4'h7, 1'b0, '0},
         '{OP_STORE, 32'h0000_0000, 4'h0, 1'b1,
           '{BUS_NONE, 1'b0, 4'h0, 1'b0, 32'h0000_0000, 1'b0, 32'd3, 1'b1, ST_OM}},
         '{OP_GETM,  32'h0000_0000, 4'h9, 1'b0, '0},
         '{OP_DATA,  32'h0000_0000, 4'h0, 1'b0, '0},
         '{OP_GETM,  32'h0000_0000, 4'h3, 1'b0, '0},
         '{OP_GETS,  32'h0000_0000, 4'h1, 1'b0, '0},
         '{3'd5,     32'hFFFF_FFFF, 4'hF, 1'b1,
           '{BUS_NONE, 1'b0, 4'h0, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'd3, 1'b1, ST_I}},
         '{3'd7,     32'h1234_5678, 4'h0, 1'b1,
           '{BUS_NONE, 1'b0, 4'h0, 1'b0, 32'h1234_5678, 1'b0, 32'd3, 1'b1, ST_I}},
         '{OP_STORE, 32'hFFFF_FFFF, 4'h0, 1'b1,
           '{BUS_GETM, 1'b0, 4'h0, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'd4, 1'b0, ST_IM}},
         '{OP_DATA,  32'h0000_03FF, 4'h0, 1'b0, '0},
         '{OP_GETS,  32'hAAAA_A7FF, 4'hA, 1'b0, '0},
         '{OP_GETM,  32'h5555_57FF, 4'h5, 1'b0, '0},
         '{OP_LOAD,  32'h0000_0400, 4'h0, 1'b0, '0},
         '{OP_DATA,  32'h0000_0400, 4'h0, 1'b0, '0},
         '{OP_GETM,  32'h0000_0400, 4'h2, 1'b0, '0}
      };

      hot_lines[0] = 0;
      hot_lines[7] = LINES_DEFAULT - 1;
      for (int i = 1; i < 7; i++) hot_lines[i] = $urandom_range(1, LINES_DEFAULT - 2);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer(directed_rows[i].op, directed_rows[i].line_addr, directed_rows[i].requester,
               directed_rows[i].has_outcome, directed_rows[i].outcome);

      // mostly legal traffic on a few hot lines so lines walk through every state
      while (item_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) idx = hot_lines[$urandom_range(0, 7)];
         else idx = $urandom_range(0, LINES_DEFAULT - 1);
         addr = $urandom;
         addr = addr - (addr % LINES_DEFAULT) + idx;
         st = line_state_model[idx];
         if ($urandom_range(0, 9) == 0) op = OP_W'($urandom_range(0, 7));
         else do op = OP_W'($urandom_range(0, 4)); while (effect_of(op, st) == EFFECT_ILLEGAL);
         item_count++;
         offer(op, addr, NODE_W'($urandom_range(0, 15)), 1'b0, '0);
         if (!hold_issued && item_count >= HOLD_AFTER) begin
            hold_issued = 1'b1;
            hold_off_due = 1'b1;
         end
         if (item_count >= RANDOM_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
      end
      req_ch.valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d transactions: %0d misses, %0d illegal, %0d data supplies,",
               checked_count, miss_seen, illegal_seen, supply_seen);
      $display("%0d processor replies, final miss count %0d, one long response hold-off",
               reply_seen, miss_count_model);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("transaction with nothing pending, out_addr", rsp_ch.out_addr, 0);
         end else begin
            oldest = pending_outcomes.pop_front();
            checked_count++;
            if (oldest.miss) miss_seen++;
            if (oldest.illegal) illegal_seen++;
            if (oldest.supply_data) supply_seen++;
            if (oldest.reply_to_proc) reply_seen++;
            if (rsp_ch.bus_request !== oldest.bus_request)
               report_mismatch("bus_request", 32'(rsp_ch.bus_request),
                               32'(oldest.bus_request));
            if (rsp_ch.supply_data !== oldest.supply_data)
               report_mismatch("supply_data", 32'(rsp_ch.supply_data),
                               32'(oldest.supply_data));
            if (rsp_ch.supply_dest !== oldest.supply_dest)
               report_mismatch("supply_dest", 32'(rsp_ch.supply_dest),
                               32'(oldest.supply_dest));
            if (rsp_ch.reply_to_proc !== oldest.reply_to_proc)
               report_mismatch("reply_to_proc", 32'(rsp_ch.reply_to_proc),
                               32'(oldest.reply_to_proc));
            if (rsp_ch.out_addr !== oldest.out_addr)
               report_mismatch("out_addr", rsp_ch.out_addr, oldest.out_addr);
            if (rsp_ch.miss !== oldest.miss)
               report_mismatch("miss", 32'(rsp_ch.miss), 32'(oldest.miss));
            if (rsp_ch.miss_total !== oldest.miss_total)
               report_mismatch("miss_total", rsp_ch.miss_total, oldest.miss_total);
            if (rsp_ch.illegal !== oldest.illegal)
               report_mismatch("illegal", 32'(rsp_ch.illegal), 32'(oldest.illegal));
            if (rsp_ch.new_state !== oldest.new_state)
               report_mismatch("new_state", 32'(rsp_ch.new_state), 32'(oldest.new_state));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transactions pending",
                  cycle_count, pending_outcomes.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

/* mosi_coherence_controller_core.f */
rtl/mcc_pkg.sv
rtl/mcc_req_if.sv
rtl/mcc_rsp_if.sv
rtl/mcc_ram.sv
rtl/mosi_coherence_controller_core.sv
tb/mosi_coherence_controller_core_test.sv
